FILE: rtl/ins_sort_pkg.sv
// Package with the shared constants, types and the sequencer state encoding of the sorter.
`timescale 1ns / 1ps
`default_nettype none

package ins_sort_pkg;

    // Number of list elements the block can hold (2 to 64).
    localparam int CAPACITY = 32;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic [IDX_W-1:0]         t_idx;
    typedef logic [CNT_W-1:0]         t_cnt;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_KEY_RD,
        ST_KEY_LAT,
        ST_CMP,
        ST_PLACE,
        ST_OUT_RD,
        ST_OUT
    } t_state;

    // Request from the sequencer to the element store.
    typedef struct packed {
        logic  we;
        t_idx  waddr;
        t_data wdata;
        logic  re;
        t_idx  raddr;
    } t_ram_req;

endpackage

`default_nettype wire

FILE: rtl/ins_sort_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module ins_sort_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ins_sort_cmp.sv
// Shared compare unit: decides whether the held key moves past the previous element.
`timescale 1ns / 1ps
`default_nettype none

module ins_sort_cmp (
    input  wire ins_sort_pkg::t_data i_key,
    input  wire ins_sort_pkg::t_data i_prev,
    input  wire logic                i_desc,
    output logic                     o_move
);

    // Strict compares keep equal values in arrival order.
    always_comb begin
        if (i_desc) begin
            o_move = (i_key > i_prev);
        end else begin
            o_move = (i_prev > i_key);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/ins_sort_ctrl.sv
// Sequencer of the sorter: list loading, insertion passes and result emission.
`timescale 1ns / 1ps
`default_nettype none

module ins_sort_ctrl (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_desc,
    input  wire ins_sort_pkg::t_data      i_s_tdata,
    input  wire logic                     i_s_tvalid,
    input  wire logic                     i_s_tlast,
    output logic                          o_s_tready,
    output logic                          o_m_tvalid,
    output logic                          o_m_tlast,
    output logic                          o_m_tuser,
    input  wire logic                     i_m_tready,
    input  wire ins_sort_pkg::t_data      i_rdata,
    input  wire logic                     i_move,
    output ins_sort_pkg::t_data           o_key,
    output logic                          o_desc,
    output ins_sort_pkg::t_ram_req        o_ram_req
);

    ins_sort_pkg::t_state r_state, n_state;
    ins_sort_pkg::t_cnt   r_count, n_count;
    logic                 r_dropped, n_dropped;
    logic                 r_desc, n_desc;
    ins_sort_pkg::t_idx   r_last_idx, n_last_idx;
    ins_sort_pkg::t_idx   r_i, n_i;
    ins_sort_pkg::t_idx   r_j, n_j;
    ins_sort_pkg::t_idx   r_k, n_k;
    ins_sort_pkg::t_data  r_key, n_key;

    logic                 w_full;
    logic                 w_accept;
    ins_sort_pkg::t_idx   w_last_idx;

    assign w_full   = (r_count == ins_sort_pkg::t_cnt'(ins_sort_pkg::CAPACITY));
    assign w_accept = (r_state == ins_sort_pkg::ST_LOAD) && i_s_tvalid;
    assign w_last_idx = w_full ? ins_sort_pkg::t_idx'(ins_sort_pkg::CAPACITY - 1)
                               : r_count[ins_sort_pkg::IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ins_sort_pkg::ST_LOAD;
            r_count    <= '0;
            r_dropped  <= 1'b0;
            r_desc     <= 1'b0;
            r_last_idx <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_k        <= '0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_dropped  <= n_dropped;
            r_desc     <= n_desc;
            r_last_idx <= n_last_idx;
            r_i        <= n_i;
            r_j        <= n_j;
            r_k        <= n_k;
        end
        r_key <= n_key;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ins_sort_pkg::ST_LOAD: begin
                if (w_accept && i_s_tlast) begin
                    n_state = (w_last_idx == '0) ? ins_sort_pkg::ST_OUT_RD
                                                 : ins_sort_pkg::ST_KEY_RD;
                end
            end
            ins_sort_pkg::ST_KEY_RD: begin
                n_state = ins_sort_pkg::ST_KEY_LAT;
            end
            ins_sort_pkg::ST_KEY_LAT: begin
                n_state = ins_sort_pkg::ST_CMP;
            end
            ins_sort_pkg::ST_CMP: begin
                if (i_move) begin
                    n_state = (r_j == ins_sort_pkg::t_idx'(1)) ? ins_sort_pkg::ST_PLACE
                                                              : ins_sort_pkg::ST_CMP;
                end else begin
                    n_state = (r_i == r_last_idx) ? ins_sort_pkg::ST_OUT_RD
                                                  : ins_sort_pkg::ST_KEY_RD;
                end
            end
            ins_sort_pkg::ST_PLACE: begin
                n_state = (r_i == r_last_idx) ? ins_sort_pkg::ST_OUT_RD
                                              : ins_sort_pkg::ST_KEY_RD;
            end
            ins_sort_pkg::ST_OUT_RD: begin
                n_state = ins_sort_pkg::ST_OUT;
            end
            ins_sort_pkg::ST_OUT: begin
                if (i_m_tready) begin
                    n_state = (r_k == r_last_idx) ? ins_sort_pkg::ST_LOAD
                                                  : ins_sort_pkg::ST_OUT_RD;
                end
            end
            default: begin
                n_state = ins_sort_pkg::ST_LOAD;
            end
        endcase
    end

    // Outputs and store requests.
    always_comb begin
        o_s_tready = (r_state == ins_sort_pkg::ST_LOAD);
        o_m_tvalid = (r_state == ins_sort_pkg::ST_OUT);
        o_m_tlast  = (r_k == r_last_idx);
        o_m_tuser  = r_dropped;
        o_key      = r_key;
        o_desc     = r_desc;
        o_ram_req  = '0;
        case (r_state)
            ins_sort_pkg::ST_LOAD: begin
                o_ram_req.we    = w_accept && !w_full;
                o_ram_req.waddr = r_count[ins_sort_pkg::IDX_W-1:0];
                o_ram_req.wdata = i_s_tdata;
            end
            ins_sort_pkg::ST_KEY_RD: begin
                o_ram_req.re    = 1'b1;
                o_ram_req.raddr = r_i;
            end
            ins_sort_pkg::ST_KEY_LAT: begin
                o_ram_req.re    = 1'b1;
                o_ram_req.raddr = r_i - ins_sort_pkg::t_idx'(1);
            end
            ins_sort_pkg::ST_CMP: begin
                // A moving element shifts up one slot while the next one is fetched.
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_j;
                if (i_move) begin
                    o_ram_req.wdata = i_rdata;
                    o_ram_req.re    = 1'b1;
                    o_ram_req.raddr = r_j - ins_sort_pkg::t_idx'(2);
                end else begin
                    o_ram_req.wdata = r_key;
                end
            end
            ins_sort_pkg::ST_PLACE: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.waddr = r_j;
                o_ram_req.wdata = r_key;
            end
            ins_sort_pkg::ST_OUT_RD: begin
                o_ram_req.re    = 1'b1;
                o_ram_req.raddr = r_k;
            end
            ins_sort_pkg::ST_OUT: begin
                o_ram_req = '0;
            end
            default: begin
                o_ram_req = '0;
            end
        endcase
    end

    // Counters, key and list status.
    always_comb begin
        n_count    = r_count;
        n_dropped  = r_dropped;
        n_desc     = r_desc;
        n_last_idx = r_last_idx;
        n_i        = r_i;
        n_j        = r_j;
        n_k        = r_k;
        n_key      = r_key;
        case (r_state)
            ins_sort_pkg::ST_LOAD: begin
                if (w_accept) begin
                    if (w_full) begin
                        n_dropped = 1'b1;
                    end else begin
                        n_count = r_count + ins_sort_pkg::t_cnt'(1);
                    end
                    if (i_s_tlast) begin
                        n_desc     = i_desc;
                        n_last_idx = w_last_idx;
                        n_i        = ins_sort_pkg::t_idx'(1);
                        n_k        = '0;
                    end
                end
            end
            ins_sort_pkg::ST_KEY_LAT: begin
                n_key = i_rdata;
                n_j   = r_i;
            end
            ins_sort_pkg::ST_CMP: begin
                if (i_move) begin
                    n_j = r_j - ins_sort_pkg::t_idx'(1);
                end else begin
                    n_i = r_i + ins_sort_pkg::t_idx'(1);
                end
            end
            ins_sort_pkg::ST_PLACE: begin
                n_i = r_i + ins_sort_pkg::t_idx'(1);
            end
            ins_sort_pkg::ST_OUT: begin
                if (i_m_tready) begin
                    n_k = r_k + ins_sort_pkg::t_idx'(1);
                    if (r_k == r_last_idx) begin
                        n_count   = '0;
                        n_dropped = 1'b0;
                    end
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/insertion_sort_asc_desc.sv
// Top level of the list sorter: configuration register, element store, compare unit, sequencer.
//
// Usage: a list of signed 32-bit words enters on the s_axis channel, one word per
// handshake; the word with s_axis_tlast high closes the list. Up to CAPACITY words
// are stored; later words of the same list are dropped and m_axis_tuser is then high
// on every result of that list. After the closing word the block sorts the list in
// place (stable insertion sort, one compare per cycle while a key moves, on a single
// shared comparator) and sends the words out on m_axis, ascending, or descending when
// the configuration bit i_cfg_wdata was last written as 1. The last result carries
// m_axis_tlast. s_axis_tready is high while the list loads. Each inserted key is read,
// latched while the element before it is read, and compared; a compare that moves the
// key shifts one element up and fetches the next, and a key that passes every element
// is written to slot 0 in a place step. The sort is limited by the single read port of
// the element store. Emission reads each word from the store, then shows it. s_axis_tready
// is low from the closing word until the last result is taken. A stalled receiver simply
// holds m_axis_tvalid and the word in place. Reset empties the list, clears the overflow
// flag and selects ascending order; stored words are not cleared and need not be.
`timescale 1ns / 1ps
`default_nettype none

module insertion_sort_asc_desc (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration: bit 0 selects descending order.
    input  wire logic        i_cfg_wen,
    input  wire logic        i_cfg_wdata,
    // Input words.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] value
    input  wire logic        s_axis_tlast,   // last
    // Sorted words.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [31:0] m_axis_tdata,   // [31:0] sorted_value
    output logic             m_axis_tlast,   // last_out
    output logic             m_axis_tuser    // [0] overflow
);

    logic                   r_descending;
    logic                   w_move;
    logic                   w_desc;
    ins_sort_pkg::t_data    w_key;
    ins_sort_pkg::t_ram_req w_ram_req;
    logic [31:0]            w_rdata;

    // The order bit is sampled by the sequencer when a list closes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_descending <= 1'b0;
        end else if (i_cfg_wen) begin
            r_descending <= i_cfg_wdata;
        end
    end

    ins_sort_ram #(
        .WIDTH (ins_sort_pkg::DATA_W),
        .DEPTH (ins_sort_pkg::CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_req.we),
        .i_waddr (w_ram_req.waddr),
        .i_wdata (w_ram_req.wdata),
        .i_re    (w_ram_req.re),
        .i_raddr (w_ram_req.raddr),
        .o_rdata (w_rdata)
    );

    ins_sort_cmp u_cmp (
        .i_key  (w_key),
        .i_prev (w_rdata),
        .i_desc (w_desc),
        .o_move (w_move)
    );

    ins_sort_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_desc     (r_descending),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tlast  (s_axis_tlast),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tlast  (m_axis_tlast),
        .o_m_tuser  (m_axis_tuser),
        .i_m_tready (m_axis_tready),
        .i_rdata    (w_rdata),
        .i_move     (w_move),
        .o_key      (w_key),
        .o_desc     (w_desc),
        .o_ram_req  (w_ram_req)
    );

    // The store's registered read data is the output word; it holds while no read is issued.
    assign m_axis_tdata = w_rdata;

endmodule

`default_nettype wire

FILE: rtl/ins_sort_chk.sv
// Port-level checker for the list sorter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ins_sort_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        s_axis_tlast,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        m_axis_tlast,
    input wire logic        m_axis_tuser
);

    // Loading and emitting never overlap.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is offered");

    // A closing word takes input ready low.
    a_close_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input still ready after the closing word");

    // Taking the final result reopens the input.
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("input not ready after the final result");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
             && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind insertion_sort_asc_desc ins_sort_chk u_ins_sort_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
